// ===== design/trme_pkg.sv =====
// ---------------------------------------------------------------------------
// trme_pkg: shared types and constants
// Opcodes, operand kinds, micro-op encodings and the decoded instruction
// that the front end hands to the execute back end.
// ---------------------------------------------------------------------------
package trme_pkg;

    localparam int DW         = 32;
    localparam int NUM_REGS   = 5;
    localparam int REG_AW     = 3;
    localparam int MEM_WORDS  = 64;
    localparam int ADDR_LIMIT = 50;
    // highest legal address + 1: the smaller of the address limit and memory size
    localparam int ADDR_LIM   = (ADDR_LIMIT < MEM_WORDS) ? ADDR_LIMIT : MEM_WORDS;
    localparam int MEM_AW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int QDEPTH     = 2;
    localparam int QPW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW        = $clog2(QDEPTH + 1);

    // opcodes
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_PRN = 3'd3;
    localparam logic [2:0] OP_JMP = 3'd4;
    localparam logic [2:0] OP_JPN = 3'd5;
    localparam logic [2:0] OP_HLT = 3'd6;

    // operand kinds
    localparam logic [1:0] OPK_REG   = 2'd0;
    localparam logic [1:0] OPK_ADDR  = 2'd1;
    localparam logic [1:0] OPK_CONST = 2'd2;

    // source of operand x
    localparam logic [1:0] XSEL_REGA = 2'd0;
    localparam logic [1:0] XSEL_REGB = 2'd1;
    localparam logic [1:0] XSEL_MEM  = 2'd2;
    localparam logic [1:0] XSEL_IMM  = 2'd3;

    // alu function
    localparam logic [1:0] ALU_PASS = 2'd0;
    localparam logic [1:0] ALU_ADD  = 2'd1;
    localparam logic [1:0] ALU_SUB  = 2'd2;

    // branch condition
    localparam logic [1:0] BR_NONE   = 2'd0;
    localparam logic [1:0] BR_ALWAYS = 2'd1;
    localparam logic [1:0] BR_ZERO   = 2'd2;
    localparam logic [1:0] BR_NONPOS = 2'd3;

    typedef struct packed {
        logic              fault;
        logic              halt;
        logic              print;
        logic [1:0]        xsel;
        logic [1:0]        alu;
        logic [1:0]        br;
        logic [REG_AW-1:0] rega;
        logic [REG_AW-1:0] regb;
        logic [MEM_AW-1:0] mem_rd;
        logic              wr_reg;
        logic [REG_AW-1:0] wr_reg_idx;
        logic              wr_mem;
        logic [MEM_AW-1:0] wr_mem_idx;
        logic [DW-1:0]     imm;
    } trme_inst_t;

endpackage

// ===== design/toy_register_machine_execute.sv =====
// ---------------------------------------------------------------------------
// toy_register_machine_execute: execute stage of a small register machine
// Executes one decoded instruction per beat on five registers, a word
// memory and a program counter, and returns one result beat per item.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries the opcode and two tagged
//   operands. Output channel (out_valid/out_ready) carries print data, the
//   fault and halted flags and the next program counter.
//   A beat is classified on acceptance and written to a two-entry queue.
//   The back end pops it, reading the register file and data memory into the
//   execute stage registers, then executes it into the output register.
//   Throughput is one instruction per cycle while the receiver does not
//   stall, set by the read and execute stages of the back end; forwarding
//   covers back-to-back dependent instructions.
//   While the receiver stalls, the output register holds its beat, the
//   execute stage and queue fill, and in_ready drops once the queue is full.
//   Reset clears registers, memory (per-word valid bits, no clearing pass),
//   program counter and the stopped flag. After HLT or a fault every beat
//   is answered with halted set and the counter unchanged.
// ---------------------------------------------------------------------------
module toy_register_machine_execute
    import trme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [1:0]         first_kind,
    input  logic signed [31:0] first_value,
    input  logic [1:0]         second_kind,
    input  logic signed [31:0] second_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               print_valid,
    output logic signed [31:0] print_value,
    output logic               fault,
    output logic               halted,
    output logic signed [31:0] next_pc
);

    trme_inst_t dec_inst;
    trme_inst_t head_inst;
    logic       q_full;
    logic       q_nonempty;
    logic       q_pop;
    logic       push;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    trme_front u_front (
        .kind         (kind),
        .first_kind   (first_kind),
        .first_value  (first_value),
        .second_kind  (second_kind),
        .second_value (second_value),
        .inst         (dec_inst)
    );

    trme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_inst (dec_inst),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (head_inst)
    );

    trme_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_nonempty),
        .q_inst      (head_inst),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .print_valid (print_valid),
        .print_value (print_value),
        .fault       (fault),
        .halted      (halted),
        .next_pc     (next_pc)
    );

endmodule

// ===== design/trme_ram.sv =====
// ---------------------------------------------------------------------------
// trme_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module trme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/trme_front.sv =====
// ---------------------------------------------------------------------------
// trme_front: instruction classifier
// Checks operand legality and turns each beat into a decoded micro-op:
// register/memory read indexes, write target, alu function, branch kind.
// ---------------------------------------------------------------------------
module trme_front
    import trme_pkg::*;
(
    input  logic [2:0]        kind,
    input  logic [1:0]        first_kind,
    input  logic signed [31:0] first_value,
    input  logic [1:0]        second_kind,
    input  logic signed [31:0] second_value,
    output trme_inst_t        inst
);

    logic [DW-1:0] fv;
    logic [DW-1:0] sv;
    logic          f_reg, f_addr, f_const;
    logic          s_reg, s_addr, s_const;
    logic [REG_AW-1:0] f_ridx, s_ridx;

    assign fv = first_value;
    assign sv = second_value;

    assign f_reg   = (first_kind == OPK_REG) && (fv >= DW'(1)) && (fv <= DW'(NUM_REGS));
    assign f_addr  = (first_kind == OPK_ADDR) && (fv < DW'(ADDR_LIM));
    assign f_const = (first_kind == OPK_CONST);
    assign s_reg   = (second_kind == OPK_REG) && (sv >= DW'(1)) && (sv <= DW'(NUM_REGS));
    assign s_addr  = (second_kind == OPK_ADDR) && (sv < DW'(ADDR_LIM));
    assign s_const = (second_kind == OPK_CONST);

    // register numbers 1..5 map to slots 0..4
    assign f_ridx = fv[REG_AW-1:0] - REG_AW'(1);
    assign s_ridx = sv[REG_AW-1:0] - REG_AW'(1);

    always_comb
    begin
        inst = '0;
        case (kind) inside
            OP_MOV:
            begin
                if (f_reg)
                begin
                    inst.rega = f_ridx;
                    if (s_reg)
                    begin
                        inst.xsel       = XSEL_REGA;
                        inst.wr_reg     = 1'b1;
                        inst.wr_reg_idx = s_ridx;
                    end
                    else if (s_const)
                    begin
                        inst.xsel       = XSEL_IMM;
                        inst.imm        = sv;
                        inst.wr_reg     = 1'b1;
                        inst.wr_reg_idx = f_ridx;
                    end
                    else if (s_addr)
                    begin
                        inst.xsel       = XSEL_REGA;
                        inst.wr_mem     = 1'b1;
                        inst.wr_mem_idx = sv[MEM_AW-1:0];
                    end
                    else
                    begin
                        inst.fault = 1'b1;
                    end
                end
                else if (f_addr)
                begin
                    if (s_reg)
                    begin
                        inst.xsel       = XSEL_MEM;
                        inst.mem_rd     = fv[MEM_AW-1:0];
                        inst.wr_reg     = 1'b1;
                        inst.wr_reg_idx = s_ridx;
                    end
                    else if (s_const)
                    begin
                        inst.xsel       = XSEL_IMM;
                        inst.imm        = sv;
                        inst.wr_mem     = 1'b1;
                        inst.wr_mem_idx = fv[MEM_AW-1:0];
                    end
                    else
                    begin
                        inst.fault = 1'b1;
                    end
                end
                else
                begin
                    inst.fault = 1'b1;
                end
            end
            OP_ADD, OP_SUB:
            begin
                if (f_reg && (s_reg || s_const || s_addr))
                begin
                    inst.rega       = f_ridx;
                    inst.alu        = (kind == OP_ADD) ? ALU_ADD : ALU_SUB;
                    inst.wr_reg     = 1'b1;
                    inst.wr_reg_idx = f_ridx;
                    if (s_reg)
                    begin
                        inst.xsel = XSEL_REGB;
                        inst.regb = s_ridx;
                    end
                    else if (s_const)
                    begin
                        inst.xsel = XSEL_IMM;
                        inst.imm  = sv;
                    end
                    else
                    begin
                        inst.xsel   = XSEL_MEM;
                        inst.mem_rd = sv[MEM_AW-1:0];
                    end
                end
                else
                begin
                    inst.fault = 1'b1;
                end
            end
            OP_PRN:
            begin
                inst.print = f_reg || f_const || f_addr;
                inst.fault = !(f_reg || f_const || f_addr);
                if (f_reg)
                begin
                    inst.xsel = XSEL_REGA;
                    inst.rega = f_ridx;
                end
                else if (f_const)
                begin
                    inst.xsel = XSEL_IMM;
                    inst.imm  = fv;
                end
                else
                begin
                    inst.xsel   = XSEL_MEM;
                    inst.mem_rd = fv[MEM_AW-1:0];
                end
            end
            OP_JMP, OP_JPN:
            begin
                if (f_reg && s_const)
                begin
                    inst.rega = f_ridx;
                    inst.imm  = sv;
                    inst.br   = (kind == OP_JMP) ? BR_ZERO : BR_NONPOS;
                end
                else if (!f_reg && f_const)
                begin
                    inst.imm = fv;
                    inst.br  = BR_ALWAYS;
                end
                else
                begin
                    inst.fault = 1'b1;
                end
            end
            OP_HLT:
            begin
                inst.halt = 1'b1;
            end
            default:
            begin
                inst.fault = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/trme_queue.sv =====
// ---------------------------------------------------------------------------
// trme_queue: decoded instruction queue
// Small register FIFO between the classifier and the execute back end.
// ---------------------------------------------------------------------------
module trme_queue
    import trme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  trme_inst_t push_inst,
    output logic       full,
    input  logic       pop,
    output logic       nonempty,
    output trme_inst_t head
);

    trme_inst_t       entry_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    assign full     = (count_reg == QCW'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        count_next = count_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_inst;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != QCW'(QDEPTH))
        else $error("queue pushed while full");

endmodule

// ===== design/trme_back.sv =====
// ---------------------------------------------------------------------------
// trme_back: execute back end
// Pops a micro-op, reads the register file and data memory, then executes:
// alu, write-back, branch resolution, halt tracking, output register.
// ---------------------------------------------------------------------------
module trme_back
    import trme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  trme_inst_t         q_inst,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               print_valid,
    output logic signed [31:0] print_value,
    output logic               fault,
    output logic               halted,
    output logic signed [31:0] next_pc
);

    // execute stage
    logic              x_vld_reg;
    trme_inst_t        x_inst_reg;
    logic              ra_vld_reg, rb_vld_reg, m_vld_reg;
    logic              x_adv;

    // machine state
    logic              stopped_reg, stopped_next;
    logic [DW-1:0]     pc_reg, pc_next;
    logic [NUM_REGS-1:0]  reg_vld_reg;
    logic [MEM_WORDS-1:0] mem_vld_reg;

    // last write to each space, forwarded past the read-old RAM
    logic              byp_reg_vld_reg;
    logic [REG_AW-1:0] byp_reg_idx_reg;
    logic [DW-1:0]     byp_reg_data_reg;
    logic              byp_mem_vld_reg;
    logic [MEM_AW-1:0] byp_mem_idx_reg;
    logic [DW-1:0]     byp_mem_data_reg;

    // output register
    logic              o_vld_reg;
    logic              o_print_valid_reg;
    logic [DW-1:0]     o_print_value_reg;
    logic              o_fault_reg;
    logic              o_halted_reg;
    logic [DW-1:0]     o_next_pc_reg;

    logic [DW-1:0]     ram_a_rdata, ram_b_rdata, ram_m_rdata;
    logic [DW-1:0]     rega_val, regb_val, mem_val, x_val, alu_res;
    logic              take;
    logic              reg_we, mem_we;

    assign x_adv = x_vld_reg && (!o_vld_reg || out_ready);
    assign q_pop = q_valid && (!x_vld_reg || x_adv);

    assign reg_we = x_adv && !stopped_reg && x_inst_reg.wr_reg;
    assign mem_we = x_adv && !stopped_reg && x_inst_reg.wr_mem;

    // register file duplicated for two read ports
    trme_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_regs_a (
        .clk   (clk),
        .we    (reg_we),
        .waddr (x_inst_reg.wr_reg_idx),
        .wdata (alu_res),
        .re    (q_pop),
        .raddr (q_inst.rega),
        .rdata (ram_a_rdata)
    );

    trme_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_regs_b (
        .clk   (clk),
        .we    (reg_we),
        .waddr (x_inst_reg.wr_reg_idx),
        .wdata (alu_res),
        .re    (q_pop),
        .raddr (q_inst.regb),
        .rdata (ram_b_rdata)
    );

    trme_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (x_inst_reg.wr_mem_idx),
        .wdata (alu_res),
        .re    (q_pop),
        .raddr (q_inst.mem_rd),
        .rdata (ram_m_rdata)
    );

    always_comb
    begin
        if (byp_reg_vld_reg && byp_reg_idx_reg == x_inst_reg.rega)
        begin
            rega_val = byp_reg_data_reg;
        end
        else
        begin
            rega_val = ra_vld_reg ? ram_a_rdata : '0;
        end

        if (byp_reg_vld_reg && byp_reg_idx_reg == x_inst_reg.regb)
        begin
            regb_val = byp_reg_data_reg;
        end
        else
        begin
            regb_val = rb_vld_reg ? ram_b_rdata : '0;
        end

        if (byp_mem_vld_reg && byp_mem_idx_reg == x_inst_reg.mem_rd)
        begin
            mem_val = byp_mem_data_reg;
        end
        else
        begin
            mem_val = m_vld_reg ? ram_m_rdata : '0;
        end

        case (x_inst_reg.xsel)
            XSEL_REGA: x_val = rega_val;
            XSEL_REGB: x_val = regb_val;
            XSEL_MEM:  x_val = mem_val;
            default:   x_val = x_inst_reg.imm;
        endcase

        case (x_inst_reg.alu)
            ALU_ADD: alu_res = rega_val + x_val;
            ALU_SUB: alu_res = rega_val - x_val;
            default: alu_res = x_val;
        endcase

        case (x_inst_reg.br)
            BR_ALWAYS: take = 1'b1;
            BR_ZERO:   take = (rega_val == '0);
            BR_NONPOS: take = (rega_val == '0) || rega_val[DW-1];
            default:   take = 1'b0;
        endcase

        if (stopped_reg)
        begin
            pc_next      = pc_reg;
            stopped_next = 1'b1;
        end
        else
        begin
            pc_next      = take ? x_inst_reg.imm : pc_reg + DW'(1);
            stopped_next = x_inst_reg.halt || x_inst_reg.fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg       <= 1'b0;
            o_vld_reg       <= 1'b0;
            stopped_reg     <= 1'b0;
            pc_reg          <= '0;
            reg_vld_reg     <= '0;
            mem_vld_reg     <= '0;
            byp_reg_vld_reg <= 1'b0;
            byp_mem_vld_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                x_vld_reg <= 1'b1;
            end
            else if (x_adv)
            begin
                x_vld_reg <= 1'b0;
            end

            if (x_adv)
            begin
                o_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_vld_reg <= 1'b0;
            end

            if (x_adv)
            begin
                stopped_reg <= stopped_next;
                pc_reg      <= pc_next;
            end

            if (reg_we)
            begin
                reg_vld_reg[x_inst_reg.wr_reg_idx] <= 1'b1;
                byp_reg_vld_reg                    <= 1'b1;
            end
            if (mem_we)
            begin
                mem_vld_reg[x_inst_reg.wr_mem_idx] <= 1'b1;
                byp_mem_vld_reg                    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            x_inst_reg <= q_inst;
            ra_vld_reg <= reg_vld_reg[q_inst.rega];
            rb_vld_reg <= reg_vld_reg[q_inst.regb];
            m_vld_reg  <= mem_vld_reg[q_inst.mem_rd];
        end
        if (reg_we)
        begin
            byp_reg_idx_reg  <= x_inst_reg.wr_reg_idx;
            byp_reg_data_reg <= alu_res;
        end
        if (mem_we)
        begin
            byp_mem_idx_reg  <= x_inst_reg.wr_mem_idx;
            byp_mem_data_reg <= alu_res;
        end
        if (x_adv)
        begin
            o_print_valid_reg <= !stopped_reg && x_inst_reg.print;
            o_print_value_reg <= (!stopped_reg && x_inst_reg.print) ? x_val : '0;
            o_fault_reg       <= !stopped_reg && x_inst_reg.fault;
            o_halted_reg      <= stopped_next;
            o_next_pc_reg     <= pc_next;
        end
    end

    assign out_valid   = o_vld_reg;
    assign print_valid = o_print_valid_reg;
    assign print_value = o_print_value_reg;
    assign fault       = o_fault_reg;
    assign halted      = o_halted_reg;
    assign next_pc     = o_next_pc_reg;

    a_no_write_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (reg_we || mem_we) |-> !stopped_reg)
        else $error("state written while machine stopped");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("machine left the stopped state");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault) |-> (halted && !print_valid))
        else $error("fault beat without halt");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("execute popped an empty queue");

endmodule
